[rtl/core/tccs_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccs_pkg
// Shared constants and control/status types for the text console writer.
// ============================================================================
package tccs_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CELL_W    = CHAR_W + ATTR_W;
  localparam int unsigned PORT_ROW_W = 5;
  localparam int unsigned PORT_COL_W = 7;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0]  REG_TEXT_ATTR = 1'b0;

  localparam logic        CMD_PUT  = 1'b0;
  localparam logic        CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic calc_row;
    logic calc_addr;
    logic mem_wr;
    logic mem_rd;
    logic advance;
    logic scrl_step;
    logic result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_newline;
    logic in_range;
    logic need_scroll;
    logic clr_last;
    logic row_last;
  } dp_sts_t;

endpackage

[rtl/core/tccs_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccs_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ============================================================================
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/tccs_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccs_ctrl
// Sequencer: post-reset clear sweep, per-beat steps, scroll blanking sweep.
// ============================================================================
module tccs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  tccs_pkg::dp_sts_t   sts,
  output tccs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ROW   = 8'b0000_0100,
    S_ADDR  = 8'b0000_1000,
    S_MEM   = 8'b0001_0000,
    S_ADV   = 8'b0010_0000,
    S_SCRL  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        cmd.calc_row = 1'b1;
        state_nxt    = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        if (sts.is_read) begin
          state_nxt = sts.in_range ? S_MEM : S_DONE;
        end else begin
          state_nxt = sts.is_newline ? S_ADV : S_MEM;
        end
      end
      S_MEM: begin
        if (sts.is_read) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.mem_wr = 1'b1;
          state_nxt  = S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = sts.need_scroll ? S_SCRL : S_DONE;
      end
      S_SCRL: begin
        cmd.scrl_step = 1'b1;
        if (sts.row_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/tccs_dp.sv]
`timescale 1ns / 1ps
// ============================================================================
// tccs_dp
// Datapath: cursor, ring top-row offset, cell address, cell RAM, result regs.
// ============================================================================
module tccs_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tccs_pkg::ctrl_cmd_t                 cmd,
  output tccs_pkg::dp_sts_t                   sts,
  input  logic [tccs_pkg::ATTR_W-1:0]         text_attr,
  input  logic                                in_cmd,
  input  logic [tccs_pkg::CHAR_W-1:0]         in_character,
  input  logic [tccs_pkg::PORT_ROW_W-1:0]     in_read_row,
  input  logic [tccs_pkg::PORT_COL_W-1:0]     in_read_col,
  output logic [tccs_pkg::CHAR_W-1:0]         out_cell_char,
  output logic [tccs_pkg::ATTR_W-1:0]         out_cell_attr,
  output logic [tccs_pkg::PORT_ROW_W-1:0]     out_cursor_row,
  output logic [tccs_pkg::PORT_COL_W-1:0]     out_cursor_col,
  output logic                                out_scrolled
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  // latched beat
  logic                               cmd_r;
  logic [tccs_pkg::CHAR_W-1:0]        char_r;
  logic [tccs_pkg::PORT_ROW_W-1:0]    rrow_r;
  logic [tccs_pkg::PORT_COL_W-1:0]    rcol_r;

  logic [RW-1:0] cur_row_r, top_r, prow_r;
  logic [CW-1:0] cur_col_r, col_r;
  logic          rng_r, scrl_r;
  logic [AW-1:0] addr_r, base_r, cnt_r;

  logic [tccs_pkg::CHAR_W-1:0]     res_char_r;
  logic [tccs_pkg::ATTR_W-1:0]     res_attr_r;
  logic [tccs_pkg::PORT_ROW_W-1:0] res_row_r;
  logic [tccs_pkg::PORT_COL_W-1:0] res_col_r;
  logic                            res_scrl_r;

  logic [RW-1:0]   sel_row, prow_nxt, mul_a, top_inc;
  logic [CW-1:0]   sel_col;
  logic [RW:0]     row_sum;
  logic            in_range, is_read, is_nl, col_last, row_bottom, wrap;
  logic [AW-1:0]   prod, addr_nxt, sweep_addr, ram_addr;
  logic            ram_we, ram_re;
  logic [tccs_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  assign is_read  = (cmd_r == tccs_pkg::CMD_READ);
  assign is_nl    = (char_r == tccs_pkg::CHAR_NEWLINE);
  assign sel_row  = is_read ? RW'(rrow_r) : cur_row_r;
  assign sel_col  = is_read ? CW'(rcol_r) : cur_col_r;
  assign row_sum  = {1'b0, sel_row} + {1'b0, top_r};
  assign prow_nxt = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS)) : RW'(row_sum);
  assign in_range = (32'(rrow_r) < 32'(ROWS)) && (32'(rcol_r) < 32'(COLUMNS));

  // one constant multiplier: cell address, or old top row base on scroll
  assign mul_a    = cmd.advance ? top_r : prow_r;
  assign prod     = AW'(32'(mul_a) * 32'(COLUMNS));
  assign addr_nxt = prod + AW'(col_r);

  assign col_last   = (cur_col_r == CW'(COLUMNS - 1));
  assign row_bottom = (cur_row_r == RW'(ROWS - 1));
  assign wrap       = is_nl || col_last;
  assign top_inc    = (top_r == RW'(ROWS - 1)) ? '0 : RW'(top_r + 1'b1);

  assign sweep_addr = base_r + cnt_r;
  assign ram_we     = cmd.clr_step || cmd.scrl_step || cmd.mem_wr;
  assign ram_re     = cmd.mem_rd;
  assign ram_addr   = (cmd.clr_step || cmd.scrl_step) ? sweep_addr : addr_r;

  always_comb begin
    priority if (cmd.clr_step) begin
      ram_wdata = {tccs_pkg::ATTR_RESET, tccs_pkg::CHAR_SPACE};
    end else if (cmd.scrl_step) begin
      ram_wdata = {text_attr, tccs_pkg::CHAR_SPACE};
    end else begin
      ram_wdata = {text_attr, char_r};
    end
  end

  tccs_ram #(
    .WIDTH (tccs_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
      base_r    <= '0;
      cnt_r     <= '0;
      scrl_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        scrl_r <= 1'b0;
      end
      if (cmd.clr_step || cmd.scrl_step) begin
        cnt_r <= AW'(cnt_r + 1'b1);
      end
      if (cmd.advance) begin
        if (wrap) begin
          cur_col_r <= '0;
          if (row_bottom) begin
            top_r  <= top_inc;
            base_r <= prod;
            cnt_r  <= '0;
            scrl_r <= 1'b1;
          end else begin
            cur_row_r <= RW'(cur_row_r + 1'b1);
          end
        end else begin
          cur_col_r <= CW'(cur_col_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      char_r <= in_character;
      rrow_r <= in_read_row;
      rcol_r <= in_read_col;
    end
    if (cmd.calc_row) begin
      prow_r <= prow_nxt;
      col_r  <= sel_col;
      rng_r  <= in_range;
    end
    if (cmd.calc_addr) begin
      addr_r <= addr_nxt;
    end
    if (cmd.result) begin
      if (is_read && rng_r) begin
        res_char_r <= ram_rdata[tccs_pkg::CHAR_W-1:0];
        res_attr_r <= ram_rdata[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
      end else begin
        res_char_r <= '0;
        res_attr_r <= '0;
      end
      res_row_r  <= tccs_pkg::PORT_ROW_W'(cur_row_r);
      res_col_r  <= tccs_pkg::PORT_COL_W'(cur_col_r);
      res_scrl_r <= scrl_r;
    end
  end

  assign sts.is_read     = is_read;
  assign sts.is_newline  = is_nl;
  assign sts.in_range    = rng_r;
  assign sts.need_scroll = wrap && row_bottom;
  assign sts.clr_last    = (cnt_r == AW'(CELLS - 1));
  assign sts.row_last    = (cnt_r == AW'(COLUMNS - 1));

  assign out_cell_char  = res_char_r;
  assign out_cell_attr  = res_attr_r;
  assign out_cursor_row = res_row_r;
  assign out_cursor_col = res_col_r;
  assign out_scrolled   = res_scrl_r;

endmodule

[rtl/core/text_console_cursor_scroll_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// text_console_cursor_scroll_unit
// Text-mode console writer: put-character and read-cell over a ROWS x COLUMNS
// cell RAM, with cursor wrap and one-row scroll.
// ============================================================================
// After reset the unit sweeps the whole cell RAM to spaces with attribute
// 0x0F, one cell per cycle; no beat is taken during that sweep, configuration
// writes are. A beat steps through the row, address and memory states to the
// result state, a put beat also through the advance state; an off-screen read
// or a newline skips the memory access. The steps are set by the single-port
// cell RAM and the address steps (ring row offset, then row times COLUMNS).
// Scrolling moves only the top-row offset; the new bottom row is then blanked
// with the current attribute in an extra sweep. A new beat is taken while the
// previous result still waits at the output register.
module text_console_cursor_scroll_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic [tccs_pkg::CHAR_W-1:0]          in_character,
  input  logic [tccs_pkg::PORT_ROW_W-1:0]      in_read_row,
  input  logic [tccs_pkg::PORT_COL_W-1:0]      in_read_col,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tccs_pkg::CHAR_W-1:0]          out_cell_char,
  output logic [tccs_pkg::ATTR_W-1:0]          out_cell_attr,
  output logic [tccs_pkg::PORT_ROW_W-1:0]      out_cursor_row,
  output logic [tccs_pkg::PORT_COL_W-1:0]      out_cursor_col,
  output logic                                 out_scrolled,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tccs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [tccs_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [tccs_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  logic [tccs_pkg::ATTR_W-1:0] text_attr_r;
  logic                        reg_hit;
  tccs_pkg::ctrl_cmd_t         cmd;
  tccs_pkg::dp_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[tccs_pkg::CFG_ADDR_W-1:2] == tccs_pkg::REG_TEXT_ATTR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tccs_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      text_attr_r <= pwdata[tccs_pkg::ATTR_W-1:0];
    end
  end

  assign prdata = reg_hit ? tccs_pkg::CFG_DATA_W'(text_attr_r) : '0;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tccs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .text_attr      (text_attr_r),
    .in_cmd         (in_cmd),
    .in_character   (in_character),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the text console cursor/scroll writer.
// ============================================================================
// Random put/read beats go in over valid/ready and results come out the same
// way. A behavioral screen model predicts every result at input acceptance.
// Each result is checked field by field against the oldest prediction. The
// text attribute is rewritten between phases while the unit is idle. The
// stimulus covers the off-screen reads, control bytes, line wrap and scrolls,
// with one long back-pressure window that forces the unit to stall its input.
// ============================================================================
module tb;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int SETTLE_CYCLES = 2 * COLUMNS + 32;
  localparam int STALL_LEN     = 500;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_BEATS   = 400;

  typedef struct packed {
    logic                            cmd;
    logic [tccs_pkg::CHAR_W-1:0]     character;
    logic [tccs_pkg::PORT_ROW_W-1:0] read_row;
    logic [tccs_pkg::PORT_COL_W-1:0] read_col;
  } console_beat_t;

  typedef struct packed {
    logic [tccs_pkg::CHAR_W-1:0]     cell_char;
    logic [tccs_pkg::ATTR_W-1:0]     cell_attr;
    logic [tccs_pkg::PORT_ROW_W-1:0] cursor_row;
    logic [tccs_pkg::PORT_COL_W-1:0] cursor_col;
    logic                            scrolled;
  } console_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_cmd = tccs_pkg::CMD_PUT;
  logic [tccs_pkg::CHAR_W-1:0]     in_character = '0;
  logic [tccs_pkg::PORT_ROW_W-1:0] in_read_row = '0;
  logic [tccs_pkg::PORT_COL_W-1:0] in_read_col = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [tccs_pkg::CHAR_W-1:0]     out_cell_char;
  logic [tccs_pkg::ATTR_W-1:0]     out_cell_attr;
  logic [tccs_pkg::PORT_ROW_W-1:0] out_cursor_row;
  logic [tccs_pkg::PORT_COL_W-1:0] out_cursor_col;
  logic                            out_scrolled;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [tccs_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [tccs_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [tccs_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  console_beat_t   beat_queue[$];
  console_result_t pending_results[$];

  logic [tccs_pkg::CHAR_W-1:0] screen_char[ROWS*COLUMNS];
  logic [tccs_pkg::ATTR_W-1:0] screen_attr[ROWS*COLUMNS];
  int unsigned                 cursor_row_model;
  int unsigned                 cursor_col_model;
  logic [tccs_pkg::ATTR_W-1:0] text_attr_model;

  logic calm = 1'b0;
  logic stall_go = 1'b0;
  int   stall_cnt = 0;
  int   error_count = 0;
  int   cycle_count = 0;

  text_console_cursor_scroll_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_character  (in_character),
    .in_read_row   (in_read_row),
    .in_read_col   (in_read_col),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr),
    .out_cursor_row(out_cursor_row),
    .out_cursor_col(out_cursor_col),
    .out_scrolled  (out_scrolled),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // screen model
  // --------------------------------------------------------------------------
  task automatic scroll_screen();
    int r;
    int c;
    for (r = 1; r < ROWS; r++) begin
      for (c = 0; c < COLUMNS; c++) begin
        screen_char[(r-1)*COLUMNS+c] = screen_char[r*COLUMNS+c];
        screen_attr[(r-1)*COLUMNS+c] = screen_attr[r*COLUMNS+c];
      end
    end
    for (c = 0; c < COLUMNS; c++) begin
      screen_char[(ROWS-1)*COLUMNS+c] = tccs_pkg::CHAR_SPACE;
      screen_attr[(ROWS-1)*COLUMNS+c] = text_attr_model;
    end
    cursor_row_model = ROWS - 1;
  endtask

  task automatic predict_console(input console_beat_t b);
    console_result_t res;
    res = '0;
    if (b.cmd == tccs_pkg::CMD_READ) begin
      if (b.read_row < ROWS && b.read_col < COLUMNS) begin
        res.cell_char = screen_char[b.read_row*COLUMNS+b.read_col];
        res.cell_attr = screen_attr[b.read_row*COLUMNS+b.read_col];
      end
    end else begin
      if (b.character == tccs_pkg::CHAR_NEWLINE) begin
        cursor_col_model = 0;
        cursor_row_model++;
      end else begin
        screen_char[cursor_row_model*COLUMNS+cursor_col_model] = b.character;
        screen_attr[cursor_row_model*COLUMNS+cursor_col_model] = text_attr_model;
        cursor_col_model++;
        if (cursor_col_model >= COLUMNS) begin
          cursor_col_model = 0;
          cursor_row_model++;
        end
      end
      if (cursor_row_model >= ROWS) begin
        scroll_screen();
        res.scrolled = 1'b1;
      end
    end
    res.cursor_row = tccs_pkg::PORT_ROW_W'(cursor_row_model);
    res.cursor_col = tccs_pkg::PORT_COL_W'(cursor_col_model);
    pending_results.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // input driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    console_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_console({in_cmd, in_character, in_read_row, in_read_col});
      end
      if (!in_valid || in_ready) begin
        if (beat_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          nxt = beat_queue.pop_front();
          in_valid     <= 1'b1;
          in_cmd       <= nxt.cmd;
          in_character <= nxt.character;
          in_read_row  <= nxt.read_row;
          in_read_col  <= nxt.read_col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    console_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no pending prediction");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("cell_char", 32'(want.cell_char), 32'(out_cell_char));
          check_field("cell_attr", 32'(want.cell_attr), 32'(out_cell_attr));
          check_field("cursor_row", 32'(want.cursor_row), 32'(out_cursor_row));
          check_field("cursor_col", 32'(want.cursor_col), 32'(out_cursor_col));
          check_field("scrolled", 32'(want.scrolled), 32'(out_scrolled));
        end
      end
      // long back-pressure window, counted here
      if (stall_go && stall_cnt < STALL_LEN) begin
        stall_cnt <= stall_cnt + 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_console_cursor_scroll_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic console_beat_t rand_beat();
    console_beat_t b;
    b.cmd       = tccs_pkg::CMD_PUT;
    b.character = tccs_pkg::CHAR_W'($urandom_range(0, 255));
    b.read_row  = tccs_pkg::PORT_ROW_W'($urandom_range(0, 31));
    b.read_col  = tccs_pkg::PORT_COL_W'($urandom_range(0, 127));
    return b;
  endfunction

  function automatic console_beat_t put_beat(input logic [tccs_pkg::CHAR_W-1:0] ch);
    console_beat_t b;
    b = rand_beat();
    b.character = ch;
    return b;
  endfunction

  function automatic console_beat_t read_beat(input int r, input int c);
    console_beat_t b;
    b = rand_beat();
    b.cmd      = tccs_pkg::CMD_READ;
    b.read_row = tccs_pkg::PORT_ROW_W'(r);
    b.read_col = tccs_pkg::PORT_COL_W'(c);
    return b;
  endfunction

  task automatic queue_random(input int n);
    int k;
    int sel;
    int run;
    int r;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        run = $urandom_range(1, 20);
        repeat (run) beat_queue.push_back(
            put_beat(tccs_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E))));
        k += run;
      end else if (sel < 33) begin
        // long line to force wrap
        run = $urandom_range(COLUMNS, 2 * COLUMNS);
        repeat (run) beat_queue.push_back(
            put_beat(tccs_pkg::CHAR_W'($urandom_range(8'h20, 8'h7E))));
        k += run;
      end else if (sel < 40) begin
        run = $urandom_range(1, 8);
        repeat (run) beat_queue.push_back(put_beat(tccs_pkg::CHAR_NEWLINE));
        k += run;
      end else if (sel < 52) begin
        beat_queue.push_back(rand_beat());
        k++;
      end else if (sel < 90) begin
        r = ($urandom_range(0, 1) != 0) ? $urandom_range(ROWS - 2, ROWS - 1)
                                        : $urandom_range(0, ROWS - 1);
        beat_queue.push_back(read_beat(r, $urandom_range(0, COLUMNS - 1)));
        k++;
      end else begin
        beat_queue.push_back(read_beat($urandom_range(0, 31), $urandom_range(0, 127)));
        k++;
      end
    end
  endtask

  task automatic write_text_attr(input logic [tccs_pkg::ATTR_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {tccs_pkg::REG_TEXT_ATTR, 2'b00};
    pwdata  <= tccs_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    text_attr_model = value;
  endtask

  task automatic drain();
    while (beat_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    // idle gap before the next register write
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : main_seq
    int i;
    for (i = 0; i < ROWS * COLUMNS; i++) begin
      screen_char[i] = tccs_pkg::CHAR_SPACE;
      screen_attr[i] = tccs_pkg::ATTR_RESET;
    end
    cursor_row_model = 0;
    cursor_col_model = 0;
    text_attr_model  = tccs_pkg::ATTR_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges, control bytes, off-screen reads
    write_text_attr(8'h00);
    beat_queue.push_back(read_beat(0, 0));
    beat_queue.push_back(read_beat(ROWS - 1, COLUMNS - 1));
    beat_queue.push_back(read_beat(ROWS, 0));
    beat_queue.push_back(read_beat(0, COLUMNS));
    beat_queue.push_back(read_beat(31, 127));
    beat_queue.push_back(read_beat(ROWS - 1, 127));
    beat_queue.push_back(read_beat(31, 0));
    beat_queue.push_back(put_beat(8'h41));
    beat_queue.push_back(put_beat(8'h00));
    beat_queue.push_back(put_beat(8'hFF));
    beat_queue.push_back(put_beat(8'h0D));
    beat_queue.push_back(put_beat(8'h09));
    beat_queue.push_back(put_beat(tccs_pkg::CHAR_NEWLINE));
    for (i = 0; i < 6; i++) beat_queue.push_back(read_beat(0, i));
    beat_queue.push_back(read_beat(1, 0));
    drain();

    // old cells must keep their attribute
    write_text_attr(8'hFF);
    beat_queue.push_back(read_beat(0, 0));
    beat_queue.push_back(read_beat(0, 4));
    queue_random(PHASE_BEATS);
    @(posedge clk);
    stall_go <= 1'b1;
    drain();

    write_text_attr(tccs_pkg::ATTR_W'($urandom_range(0, 255)));
    @(posedge clk);
    calm <= 1'b1;
    queue_random(PHASE_BEATS);
    drain();
    calm <= 1'b0;

    write_text_attr(tccs_pkg::ATTR_RESET);
    queue_random(PHASE_BEATS);
    drain();

    write_text_attr(tccs_pkg::ATTR_W'($urandom_range(0, 255)));
    queue_random(PHASE_BEATS);
    drain();

    if (error_count == 0) begin
      $display("text_console_cursor_scroll_unit regression: pass");
    end else begin
      $display("text_console_cursor_scroll_unit regression: fail");
    end
    $finish;
  end

endmodule
